// ===== design/draw_command_batcher_top_defines.svh =====
// assertion macros used by the checker file
`ifndef DRAW_COMMAND_BATCHER_TOP_DEFINES_SVH
`define DRAW_COMMAND_BATCHER_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define DCB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define DCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dcb_pkg.sv =====
package dcb_pkg;

  localparam int unsigned MaxItems     = 65536;
  localparam int unsigned VertexBytes  = 32;
  localparam int unsigned CommandBytes = 24;
  localparam int unsigned IndexShift   = 2;
  localparam int unsigned CntW         = $clog2(MaxItems + 1);
  localparam int unsigned PosW         = 16;
  localparam int unsigned NumSlots     = 5;

  typedef enum logic [1:0] {
    KindDraw  = 2'd0,
    KindBatch = 2'd1,
    KindMap   = 2'd2
  } kind_e;

  // register word index, taken from paddr[2]
  localparam logic RegCull = 1'b0;
  localparam logic RegBase = 1'b1;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] index_count;
    logic [16:0] instance_count;
    logic [29:0] first_index;
    logic [30:0] vertex_offset;
    logic [15:0] base_instance;
    logic [7:0]  batch_archetype;
    logic [3:0]  batch_topology;
    logic [31:0] buffer_offset;
    logic [16:0] draw_count;
    logic [16:0] command_index;
    logic        last_of_run;
  } result_t;

endpackage

// ===== design/draw_command_batcher_top.sv =====
// latency: an accepted item passes the input register, the result buffer and the output register before m_axis
// throughput: one item per cycle while each item causes at most one result and m_axis is not stalled;
//   while an item's results remain in the five-entry result buffer, the next item waits in the input
//   register, as the single output register drains the buffer one result at a time
// reset: asynchronous, active low; clears configuration, run state, counters and valid flags, not data registers
module draw_command_batcher_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // archetype_id, topology_id, mesh_id, mesh_index_count,
  // mesh_index_byte_offset, mesh_vertex_byte_offset, zero fill
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // index_count, instance_count, first_index, vertex_offset, base_instance,
  // batch_archetype, batch_topology, buffer_offset, draw_count,
  // command_index, zero fill
  output logic [207:0] m_axis_tdata,
  // kind
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned CntW = dcb_pkg::CntW;
  localparam int unsigned PosW = dcb_pkg::PosW;
  localparam int unsigned NumSlots = dcb_pkg::NumSlots;
  localparam int unsigned SelW = $clog2(NumSlots);
  localparam logic [CntW-1:0] CntMax = CntW'(dcb_pkg::MaxItems);
  localparam logic [CntW-1:0] PosMax = CntW'(dcb_pkg::MaxItems - 1);

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] x);
    sat_inc = (x < CntMax) ? x + CntW'(1) : CntMax;
  endfunction

  // configuration
  logic        cull_q;
  logic [31:0] base_q;

  // input register
  logic        in_vld_q;
  logic [7:0]  in_arch_q;
  logic [3:0]  in_topo_q;
  logic [15:0] in_mesh_q;
  logic [31:0] in_icnt_q, in_ioff_q, in_voff_q;
  logic        in_last_q;

  // run and batch state
  logic            started_q, started_d;
  logic [7:0]      cur_arch_q, cur_arch_d;
  logic [3:0]      cur_topo_q, cur_topo_d;
  logic [15:0]     cur_mesh_q, cur_mesh_d;
  logic [31:0]     held_icnt_q, held_icnt_d;
  logic [31:0]     held_ioff_q, held_ioff_d;
  logic [31:0]     held_voff_q, held_voff_d;
  logic [PosW-1:0] run_start_q, run_start_d;
  logic [CntW-1:0] run_inst_q, run_inst_d;
  logic [CntW-1:0] cmd_wr_q, cmd_wr_d;
  logic [CntW-1:0] cmd_in_batch_q, cmd_in_batch_d;
  logic [CntW-1:0] batch_start_q, batch_start_d;
  logic [CntW-1:0] item_pos_q, item_pos_d;

  // result buffer and output register
  dcb_pkg::result_t job_q [NumSlots];
  logic [NumSlots-1:0] job_mask_q, job_mask_d;
  dcb_pkg::result_t out_q;
  logic out_vld_q;

  // per item logic
  logic group_chg, key_chg, close_draw, take_new, flush_draw, flush_batch;
  logic [CntW-1:0] cw1, cw2, cib1, cib2, cib3, ri1, ri2, bs_n, pos_n;
  logic [7:0]  arch_n;
  logic [3:0]  topo_n;
  logic [15:0] mesh_n;
  logic [31:0] icnt_n, ioff_n, voff_n;
  logic [PosW-1:0] run_start_n;
  logic [31:0] vdiv_cur, vdiv_new, off_cur, off_new;
  dcb_pkg::result_t rec [NumSlots];
  logic [NumSlots-1:0] new_mask;
  logic later;

  // buffer drain
  logic [NumSlots-1:0] low_bit, mask_after_pop;
  logic [SelW-1:0] sel;
  logic pop, proc_go, in_accept;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == dcb_pkg::RegBase) ? base_q : {31'b0, cull_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cull_q <= 1'b0;
      base_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        dcb_pkg::RegCull: cull_q <= pwdata[0];
        dcb_pkg::RegBase: base_q <= pwdata;
        default: ;
      endcase
    end
  end

  // drain side: pick the lowest pending result
  assign pop = (|job_mask_q) && (!out_vld_q || m_axis_tready);
  assign low_bit = job_mask_q & (~job_mask_q + NumSlots'(1));
  assign mask_after_pop = pop ? (job_mask_q & ~low_bit) : job_mask_q;
  assign proc_go = in_vld_q && (mask_after_pop == '0);
  assign s_axis_tready = !in_vld_q || proc_go;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    sel = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (job_mask_q[i]) begin
        sel = SelW'(i);
      end
    end
  end

  assign job_mask_d = proc_go ? new_mask : mask_after_pop;

  // item decode and state update
  assign group_chg = started_q && ((in_arch_q != cur_arch_q) || (in_topo_q != cur_topo_q));
  assign key_chg = group_chg || (started_q && (in_mesh_q != cur_mesh_q));
  assign close_draw = key_chg && (run_inst_q != '0);
  assign take_new = !started_q || close_draw;

  assign cw1 = close_draw ? sat_inc(cmd_wr_q) : cmd_wr_q;
  assign cib1 = close_draw ? sat_inc(cmd_in_batch_q) : cmd_in_batch_q;
  assign ri1 = close_draw ? '0 : run_inst_q;
  assign cib2 = group_chg ? '0 : cib1;
  assign bs_n = group_chg ? cw1 : batch_start_q;
  assign ri2 = sat_inc(ri1);
  assign pos_n = (item_pos_q < PosMax) ? item_pos_q + CntW'(1) : item_pos_q;

  assign icnt_n = take_new ? in_icnt_q : held_icnt_q;
  assign ioff_n = take_new ? in_ioff_q : held_ioff_q;
  assign voff_n = take_new ? in_voff_q : held_voff_q;
  assign mesh_n = take_new ? in_mesh_q : cur_mesh_q;
  assign run_start_n = take_new ? item_pos_q[PosW-1:0] : run_start_q;
  assign arch_n = (!started_q || group_chg) ? in_arch_q : cur_arch_q;
  assign topo_n = (!started_q || group_chg) ? in_topo_q : cur_topo_q;

  assign flush_draw = in_last_q && (ri2 != '0);
  assign cw2 = flush_draw ? sat_inc(cw1) : cw1;
  assign cib3 = flush_draw ? sat_inc(cib2) : cib2;
  assign flush_batch = in_last_q && (cib3 != '0);

  assign vdiv_cur = held_voff_q / 32'(dcb_pkg::VertexBytes);
  assign vdiv_new = voff_n / 32'(dcb_pkg::VertexBytes);
  assign off_cur = base_q + 32'(batch_start_q) * 32'(dcb_pkg::CommandBytes);
  assign off_new = base_q + 32'(bs_n) * 32'(dcb_pkg::CommandBytes);

  assign new_mask = {flush_batch, flush_draw, cull_q, group_chg, close_draw};

  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      rec[i] = '0;
    end
    // closed draw command
    rec[0].kind = dcb_pkg::KindDraw;
    rec[0].index_count = held_icnt_q;
    rec[0].instance_count = cull_q ? '0 : run_inst_q;
    rec[0].first_index = held_ioff_q[31:dcb_pkg::IndexShift];
    rec[0].vertex_offset = vdiv_cur[30:0];
    rec[0].base_instance = run_start_q;
    rec[0].command_index = cmd_wr_q;
    // closed batch record
    rec[1].kind = dcb_pkg::KindBatch;
    rec[1].batch_archetype = cur_arch_q;
    rec[1].batch_topology = cur_topo_q;
    rec[1].buffer_offset = off_cur;
    rec[1].draw_count = cib1;
    // map entry
    rec[2].kind = dcb_pkg::KindMap;
    rec[2].command_index = cw1;
    // flushed draw command
    rec[3].kind = dcb_pkg::KindDraw;
    rec[3].index_count = icnt_n;
    rec[3].instance_count = cull_q ? '0 : ri2;
    rec[3].first_index = ioff_n[31:dcb_pkg::IndexShift];
    rec[3].vertex_offset = vdiv_new[30:0];
    rec[3].base_instance = run_start_n;
    rec[3].command_index = cw1;
    // flushed batch record
    rec[4].kind = dcb_pkg::KindBatch;
    rec[4].batch_archetype = arch_n;
    rec[4].batch_topology = topo_n;
    rec[4].buffer_offset = off_new;
    rec[4].draw_count = cib3;
    later = 1'b0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      rec[i].last_of_run = new_mask[i] && !later;
      later = later || new_mask[i];
    end
  end

  always_comb begin
    if (in_last_q) begin
      started_d = 1'b0;
      cur_arch_d = '0;
      cur_topo_d = '0;
      cur_mesh_d = '0;
      held_icnt_d = '0;
      held_ioff_d = '0;
      held_voff_d = '0;
      run_start_d = '0;
      run_inst_d = '0;
      cmd_wr_d = '0;
      cmd_in_batch_d = '0;
      batch_start_d = '0;
      item_pos_d = '0;
    end else begin
      started_d = 1'b1;
      cur_arch_d = arch_n;
      cur_topo_d = topo_n;
      cur_mesh_d = mesh_n;
      held_icnt_d = icnt_n;
      held_ioff_d = ioff_n;
      held_voff_d = voff_n;
      run_start_d = run_start_n;
      run_inst_d = ri2;
      cmd_wr_d = cw2;
      cmd_in_batch_d = cib3;
      batch_start_d = bs_n;
      item_pos_d = pos_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      cur_arch_q <= '0;
      cur_topo_q <= '0;
      cur_mesh_q <= '0;
      held_icnt_q <= '0;
      held_ioff_q <= '0;
      held_voff_q <= '0;
      run_start_q <= '0;
      run_inst_q <= '0;
      cmd_wr_q <= '0;
      cmd_in_batch_q <= '0;
      batch_start_q <= '0;
      item_pos_q <= '0;
    end else if (proc_go) begin
      started_q <= started_d;
      cur_arch_q <= cur_arch_d;
      cur_topo_q <= cur_topo_d;
      cur_mesh_q <= cur_mesh_d;
      held_icnt_q <= held_icnt_d;
      held_ioff_q <= held_ioff_d;
      held_voff_q <= held_voff_d;
      run_start_q <= run_start_d;
      run_inst_q <= run_inst_d;
      cmd_wr_q <= cmd_wr_d;
      cmd_in_batch_q <= cmd_in_batch_d;
      batch_start_q <= batch_start_d;
      item_pos_q <= item_pos_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (proc_go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_arch_q <= s_axis_tdata[7:0];
      in_topo_q <= s_axis_tdata[11:8];
      in_mesh_q <= s_axis_tdata[27:12];
      in_icnt_q <= s_axis_tdata[59:28];
      in_ioff_q <= s_axis_tdata[91:60];
      in_voff_q <= s_axis_tdata[123:92];
      in_last_q <= s_axis_tlast;
    end
  end

  // result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_mask_q <= '0;
    end else begin
      job_mask_q <= job_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go) begin
      for (int i = 0; i < NumSlots; i++) begin
        job_q[i] <= rec[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pop) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= job_q[sel];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser = out_q.kind;
  assign m_axis_tlast = out_q.last_of_run;
  assign m_axis_tdata = {4'b0, out_q.command_index, out_q.draw_count, out_q.buffer_offset,
                         out_q.batch_topology, out_q.batch_archetype, out_q.base_instance,
                         out_q.vertex_offset, out_q.first_index, out_q.instance_count,
                         out_q.index_count};

endmodule

// ===== design/dcb_checker.sv =====
`include "draw_command_batcher_top_defines.svh"

module dcb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic [207:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);

  // a stalled item stays offered
  `DCB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output valid dropped while stalled")

  // a stalled item keeps its data
  `DCB_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output data changed while stalled")

  // a closed batch always holds at least one command
  `DCB_ASSERT(a_batch_count, m_axis_tvalid && m_axis_tuser == dcb_pkg::KindBatch |-> m_axis_tdata[186:170] != '0, "batch record with zero draw count")

  // map entries carry only a command slot
  `DCB_ASSERT(a_map_clean, m_axis_tvalid && m_axis_tuser == dcb_pkg::KindMap |-> m_axis_tdata[186:0] == '0, "map entry with stray fields")

endmodule

bind draw_command_batcher_top dcb_checker u_dcb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
